// ----- rtl/pets_pkg.sv -----
// ----------------------------------------------------------------------------
// pets_pkg
// Shared types and constants for the PPS edge timestamp queue: field widths,
// register indexes and reset values, and the request/response structs of the
// shared multiply/divide unit.
// ----------------------------------------------------------------------------
package pets_pkg;

    // Field widths.
    localparam int EDGE_W    = 32;
    localparam int TIME_W    = 64;
    localparam int TICK_W    = 64;
    localparam int COUNT_W   = 32;
    localparam int HZ_W      = 30;
    localparam int CPL_W     = 8;
    localparam int FIXED_W   = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    // Queue depth default (one slot stays free, so it holds depth minus one).
    localparam int QUEUE_DEPTH_DEF = 8;

    // Microseconds per second; the multiply walks its bits one per cycle.
    localparam int US_W = 20;
    localparam logic [US_W-1:0] US_PER_SEC = US_W'(1000000);

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLED  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLK_HZ   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_US  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RELOAD   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CPL      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIXED    = 3'd5;

    // Configuration reset values.
    localparam logic [HZ_W-1:0]    RST_CLK_HZ = HZ_W'(125000000);
    localparam logic [COUNT_W-1:0] RST_RELOAD = '1;
    localparam logic [CPL_W-1:0]   RST_CPL    = CPL_W'(2);
    localparam logic [FIXED_W-1:0] RST_FIXED  = '0;

    // One queued event as stored in the ring.
    typedef struct packed {
        logic [EDGE_W-1:0] edge_count;
        logic [TIME_W-1:0] time_us;
        logic [TICK_W-1:0] tick_cycles;
    } t_event;

    localparam int EVT_W = $bits(t_event);

    // Request to the shared multiply/divide unit.
    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] operand;
        logic [HZ_W-1:0]   divisor;
    } t_alu_req;

    // Response from the shared multiply/divide unit.
    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } t_alu_rsp;

endpackage

// ----- rtl/pets_if.sv -----
// ----------------------------------------------------------------------------
// pets_if
// Valid/ready channels of the PPS edge timestamp queue: the request channel
// (capture or pop) and the event channel that returns popped events.
// ----------------------------------------------------------------------------
interface pets_cap_if;
    import pets_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [COUNT_W-1:0] remaining_count;

    modport source (output valid, output action, output remaining_count, input ready);
    modport sink   (input valid, input action, input remaining_count, output ready);
endinterface

interface pets_evt_if;
    import pets_pkg::*;

    logic              valid;
    logic              ready;
    logic              event_valid;
    logic [EDGE_W-1:0] edge_count;
    logic [TIME_W-1:0] time_us;
    logic [TICK_W-1:0] tick_cycles;

    modport source (
        output valid, output event_valid, output edge_count, output time_us,
        output tick_cycles, input ready
    );
    modport sink (
        input valid, input event_valid, input edge_count, input time_us,
        input tick_cycles, output ready
    );
endinterface

// ----- rtl/pets_ram.sv -----
// ----------------------------------------------------------------------------
// pets_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pets_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/pets_muldiv.sv -----
// ----------------------------------------------------------------------------
// pets_muldiv
// Shared iterative unit: multiplies a 64-bit cycle count by one million with
// shift-and-add (one constant bit per cycle), then divides the 64-bit product
// by the clock rate with a restoring divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module pets_muldiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pets_pkg::t_alu_req  i_req,
    output pets_pkg::t_alu_rsp  o_rsp
);
    import pets_pkg::*;

    localparam int CNT_W = $clog2(TIME_W);

    typedef enum logic [2:0] {
        ALU_IDLE = 3'b001,
        ALU_MUL  = 3'b010,
        ALU_DIV  = 3'b100
    } t_alu_state;

    t_alu_state        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [TICK_W-1:0] r_a;
    logic [TIME_W-1:0] r_p;
    logic [TIME_W-1:0] r_q;
    logic [HZ_W-1:0]   r_rem;
    logic [HZ_W-1:0]   r_div;
    logic              r_done;

    logic [TIME_W-1:0] n_p;
    logic [HZ_W:0]     n_trial;
    logic              n_fits;

    // Multiply step: add the shifted operand when the constant bit is set.
    always_comb begin
        n_p = r_p;
        if (US_PER_SEC[r_cnt[$clog2(US_W)-1:0]]) begin
            n_p = r_p + r_a;
        end
    end

    // Divide step: bring down the next dividend bit and try the subtract.
    assign n_trial = {r_rem, r_q[TIME_W-1]};
    assign n_fits  = (n_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ALU_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ALU_IDLE: begin
                    if (i_req.start) begin
                        r_state <= ALU_MUL;
                        r_cnt   <= '0;
                        r_a     <= i_req.operand;
                        r_p     <= '0;
                        r_div   <= i_req.divisor;
                    end
                end
                ALU_MUL: begin
                    r_p <= n_p;
                    r_a <= {r_a[TICK_W-2:0], 1'b0};
                    if (r_cnt == CNT_W'(US_W - 1)) begin
                        // Product complete: it becomes the dividend.
                        r_state <= ALU_DIV;
                        r_cnt   <= '0;
                        r_q     <= n_p;
                        r_rem   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ALU_DIV: begin
                    if (n_fits) begin
                        r_rem <= HZ_W'(n_trial - {1'b0, r_div});
                    end else begin
                        r_rem <= n_trial[HZ_W-1:0];
                    end
                    r_q <= {r_q[TIME_W-2:0], n_fits};
                    if (r_cnt == CNT_W'(TIME_W - 1)) begin
                        r_state <= ALU_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= ALU_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
endmodule

// ----- rtl/pps_edge_timestamp_queue_unit.sv -----
// ----------------------------------------------------------------------------
// pps_edge_timestamp_queue_unit
// Timestamps pulse-per-second edges from a down-counter capture and queues
// the events in a small ring that overwrites its oldest entry when full.
//
// Usage:
// - i_cap carries requests. action 0 is an edge capture with the counter
//   value left at the edge; action 1 pops the oldest event. Captures give
//   no word on o_evt; every pop gives exactly one word on o_evt.
// - A capture holds the request port until it is done: the elapsed
//   loops are scaled and accumulated, then the shared multiply/divide
//   unit multiplies by one million and divides by the clock rate, one
//   bit per cycle.
// - A pop reads the ring RAM (registered read) and loads the output
//   register; the request port is free again when that register loads.
// - The output register parts the two sides; a stalled receiver holds the
//   word, captures keep running, and a further pop waits for the register.
// - An empty queue, or a disabled block, answers a pop with an all-zero word.
// - Reset clears the accumulator, edge counter, ring pointers and the
//   registers to their defaults; the ring contents are not cleared.
// - Registers are written over i_cfg_* while no request is in progress.
// ----------------------------------------------------------------------------
module pps_edge_timestamp_queue_unit #(
    parameter int QUEUE_DEPTH = pets_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pets_cap_if.sink                         i_cap,
    pets_evt_if.source                       o_evt,
    input  logic                             i_cfg_we,
    input  logic [pets_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [pets_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import pets_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCALE = 6'b000010,
        ST_ACCUM = 6'b000100,
        ST_START = 6'b001000,
        ST_CONV  = 6'b010000,
        ST_READ  = 6'b100000
    } t_state;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
        return (s == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // Configuration registers.
    logic               r_enabled;
    logic [HZ_W-1:0]    r_clk_hz;
    logic [TIME_W-1:0]  r_base_us;
    logic [COUNT_W-1:0] r_reload;
    logic [CPL_W-1:0]   r_cpl;
    logic [FIXED_W-1:0] r_fixed;

    // Control and running state.
    t_state             r_state;
    logic [TICK_W-1:0]  r_acc;
    logic [EDGE_W-1:0]  r_edge;
    logic [PTR_W-1:0]   r_wr_slot;
    logic [PTR_W-1:0]   r_rd_slot;
    logic               r_hit;
    logic               r_out_valid;

    // Payload registers.
    logic [COUNT_W-1:0]       r_loops;
    logic [COUNT_W+CPL_W-1:0] r_term;
    t_event                   r_out;

    // Datapath signals.
    logic              n_accept;
    logic              n_pop_hit;
    logic              n_out_free;
    logic [PTR_W-1:0]  n_wr_next;
    logic [TIME_W-1:0] n_quot;
    t_event            n_evt;
    t_event            w_rd_evt;
    logic              w_ram_we;
    t_alu_req          w_req;
    t_alu_rsp          w_rsp;

    assign i_cap.ready = (r_state == ST_IDLE);
    assign n_accept    = i_cap.valid && i_cap.ready;
    assign n_pop_hit   = r_enabled && (r_rd_slot != r_wr_slot);
    assign n_out_free  = !r_out_valid || o_evt.ready;
    assign n_wr_next   = next_slot(r_wr_slot);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_clk_hz  <= RST_CLK_HZ;
            r_base_us <= '0;
            r_reload  <= RST_RELOAD;
            r_cpl     <= RST_CPL;
            r_fixed   <= RST_FIXED;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ENABLED: r_enabled <= i_cfg_wdata[0];
                CFG_CLK_HZ:  r_clk_hz  <= i_cfg_wdata[HZ_W-1:0];
                CFG_BASE_US: r_base_us <= i_cfg_wdata[TIME_W-1:0];
                CFG_RELOAD:  r_reload  <= i_cfg_wdata[COUNT_W-1:0];
                CFG_CPL:     r_cpl     <= i_cfg_wdata[CPL_W-1:0];
                CFG_FIXED:   r_fixed   <= i_cfg_wdata[FIXED_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared multiply/divide request: cycles plus the fixed detection delay.
    assign w_req.start   = (r_state == ST_START);
    assign w_req.operand = r_acc + TICK_W'(r_fixed);
    assign w_req.divisor = r_clk_hz;

    pets_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // A zero clock rate gives a zero quotient.
    assign n_quot = (r_clk_hz == '0) ? '0 : w_rsp.quotient;

    // Event written to the ring when the conversion finishes.
    assign n_evt.edge_count  = r_edge;
    assign n_evt.time_us     = r_base_us + n_quot;
    assign n_evt.tick_cycles = r_acc;
    assign w_ram_we          = (r_state == ST_CONV) && w_rsp.done;

    pets_ram #(
        .WIDTH (EVT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wr_slot),
        .i_wdata (n_evt),
        .i_re    (n_accept && i_cap.action && n_pop_hit),
        .i_raddr (r_rd_slot),
        .o_rdata (w_rd_evt)
    );

    // Request sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_acc     <= '0;
            r_edge    <= '0;
            r_wr_slot <= '0;
            r_rd_slot <= '0;
            r_hit     <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        if (i_cap.action) begin
                            // Pop: issue the ring read now; the output register takes it when free.
                            r_hit   <= n_pop_hit;
                            r_state <= ST_READ;
                            if (n_pop_hit) begin
                                r_rd_slot <= next_slot(r_rd_slot);
                            end
                        end else if (r_enabled) begin
                            r_loops <= r_reload - i_cap.remaining_count;
                            r_state <= ST_SCALE;
                        end
                    end
                end
                ST_SCALE: begin
                    r_term  <= r_loops * r_cpl;
                    r_state <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    r_acc   <= r_acc + TICK_W'(r_term);
                    r_edge  <= r_edge + 1'b1;
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_state <= ST_CONV;
                end
                ST_CONV: begin
                    if (w_rsp.done) begin
                        // Push; a full ring drops its oldest event.
                        r_wr_slot <= n_wr_next;
                        if (n_wr_next == r_rd_slot) begin
                            r_rd_slot <= next_slot(r_rd_slot);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_READ: begin
                    if (n_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register for popped events.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_READ) && n_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_READ) && n_out_free) begin
            r_out <= r_hit ? w_rd_evt : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_READ) && n_out_free) begin
            o_evt.event_valid <= r_hit;
        end
    end

    assign o_evt.valid       = r_out_valid;
    assign o_evt.edge_count  = r_out.edge_count;
    assign o_evt.time_us     = r_out.time_us;
    assign o_evt.tick_cycles = r_out.tick_cycles;
endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PPS edge timestamp queue. A behavioral model
// of the cycle accumulator, the microsecond conversion and the overwriting
// ring predicts every event word; each word taken from the event channel is
// compared with the oldest prediction. Directed cases cover the register
// extremes, empty, disabled and overflowing queues; random phases follow
// with random settings, random idling on both channels and bursts of
// captures and pops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import pets_pkg::*;

// Request kinds on the capture channel.
typedef enum logic {
    ACT_CAPTURE = 1'b0,
    ACT_POP     = 1'b1
} request_kind_t;

// One predicted word on the event channel.
typedef struct packed {
    logic   valid;
    t_event ev;
} event_word_t;

// One full register setting.
typedef struct packed {
    logic               en;
    logic [HZ_W-1:0]    hz;
    logic [TIME_W-1:0]  base;
    logic [COUNT_W-1:0] reload;
    logic [CPL_W-1:0]   cpl;
    logic [FIXED_W-1:0] fixed;
} setting_t;

// Event model: register copies, accumulator, edge counter, ring, and the
// queue of event words still to come.
class pps_event_model;
    logic               enabled;
    logic [HZ_W-1:0]    clk_hz;
    logic [TIME_W-1:0]  base_us;
    logic [COUNT_W-1:0] reload;
    logic [CPL_W-1:0]   cpl;
    logic [FIXED_W-1:0] fixed_cycles;
    logic [TICK_W-1:0]  cycle_acc;
    logic [EDGE_W-1:0]  edge_total;
    int unsigned        wr_slot;
    int unsigned        rd_slot;
    t_event             ring [QUEUE_DEPTH_DEF];
    event_word_t        expected_events [$];
    int unsigned        errors;

    function void reset_state();
        enabled      = 1'b0;
        clk_hz       = RST_CLK_HZ;
        base_us      = '0;
        reload       = RST_RELOAD;
        cpl          = RST_CPL;
        fixed_cycles = RST_FIXED;
        cycle_acc    = '0;
        edge_total   = '0;
        wr_slot      = 0;
        rd_slot      = 0;
        errors       = 0;
        expected_events.delete();
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLED: enabled      = data[0];
            CFG_CLK_HZ:  clk_hz       = data[HZ_W-1:0];
            CFG_BASE_US: base_us      = data[TIME_W-1:0];
            CFG_RELOAD:  reload       = data[COUNT_W-1:0];
            CFG_CPL:     cpl          = data[CPL_W-1:0];
            CFG_FIXED:   fixed_cycles = data[FIXED_W-1:0];
            default: ;
        endcase
    endfunction

    // An enabled capture updates the ring; a pop predicts one event word.
    function void note_request(logic act, logic [COUNT_W-1:0] rem);
        logic [COUNT_W-1:0] loops;
        logic [TICK_W-1:0]  total;
        logic [TICK_W-1:0]  scaled;
        logic [TIME_W-1:0]  quot;
        t_event             ev;
        event_word_t        word;
        int unsigned        nxt;

        if (act == ACT_CAPTURE) begin
            if (!enabled) return;
            loops      = reload - rem;
            cycle_acc  = cycle_acc + 64'(loops) * 64'(cpl);
            edge_total = edge_total + 1;
            total      = cycle_acc + 64'(fixed_cycles);
            scaled     = total * 64'd1000000;
            quot       = (clk_hz == '0) ? '0 : scaled / {34'd0, clk_hz};
            ev.edge_count  = edge_total;
            ev.time_us     = base_us + quot;
            ev.tick_cycles = cycle_acc;
            // A full ring loses its oldest event.
            nxt = (wr_slot + 1) % QUEUE_DEPTH_DEF;
            if (nxt == rd_slot) rd_slot = (rd_slot + 1) % QUEUE_DEPTH_DEF;
            ring[wr_slot] = ev;
            wr_slot = nxt;
        end else begin
            word = '0;
            if (enabled && rd_slot != wr_slot) begin
                word.valid = 1'b1;
                word.ev    = ring[rd_slot];
                rd_slot    = (rd_slot + 1) % QUEUE_DEPTH_DEF;
            end
            expected_events.push_back(word);
        end
    endfunction

    function void check_event(logic v, logic [EDGE_W-1:0] e, logic [TIME_W-1:0] t,
                              logic [TICK_W-1:0] k);
        event_word_t want;

        if (expected_events.size() == 0) begin
            $error("event word with none expected");
            errors++;
            return;
        end
        want = expected_events.pop_front();
        if (v !== want.valid) begin
            $error("event_valid: expected %0d, got %0d", want.valid, v);
            errors++;
        end
        if (e !== want.ev.edge_count) begin
            $error("edge_count: expected %0h, got %0h", want.ev.edge_count, e);
            errors++;
        end
        if (t !== want.ev.time_us) begin
            $error("time_us: expected %0h, got %0h", want.ev.time_us, t);
            errors++;
        end
        if (k !== want.ev.tick_cycles) begin
            $error("tick_cycles: expected %0h, got %0h", want.ev.tick_cycles, k);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 136;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  quiet_mode;
    int                    idle_cycles;
    int                    stall_left;
    int                    run_left;
    pps_event_model        model;

    pets_cap_if cap_bus ();
    pets_evt_if evt_bus ();

    pps_edge_timestamp_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (cap_bus),
        .o_evt       (evt_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Monitor both channels and watch for a stalled run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cap_bus.valid && cap_bus.ready)
                model.note_request(cap_bus.action, cap_bus.remaining_count);
            if (evt_bus.valid && evt_bus.ready)
                model.check_event(evt_bus.event_valid, evt_bus.edge_count,
                                  evt_bus.time_us, evt_bus.tick_cycles);
            if ((cap_bus.valid && cap_bus.ready) || (evt_bus.valid && evt_bus.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Receiver: ready runs and stalls in random bursts, always high when quiet.
    always @(negedge i_clk) begin
        if (quiet_mode) begin
            evt_bus.ready <= 1'b1;
        end else if (stall_left > 0) begin
            evt_bus.ready <= 1'b0;
            stall_left--;
        end else if (run_left > 0) begin
            evt_bus.ready <= 1'b1;
            run_left--;
        end else if ($urandom_range(0, 1) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            evt_bus.ready <= 1'b0;
        end else begin
            run_left = (($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 20)) - 1;
            evt_bus.ready <= 1'b1;
        end
    end

    // Present one request word and hold it until it is taken.
    task automatic send_request(input request_kind_t kind, input logic [COUNT_W-1:0] rem);
        cap_bus.valid           <= 1'b1;
        cap_bus.action          <= kind;
        cap_bus.remaining_count <= rem;
        @(posedge i_clk);
        while (!cap_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_requests(input int n);
        cap_bus.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Stop sending and wait until every predicted word has arrived.
    task automatic wait_results();
        cap_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (model.expected_events.size() != 0) @(negedge i_clk);
    endtask

    // Let a capture that gives no word finish before touching registers.
    task automatic settle();
        wait_results();
        repeat (HOLD_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        model.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic load_setting(input setting_t s);
        settle();
        write_cfg(CFG_ENABLED, 64'(s.en));
        write_cfg(CFG_CLK_HZ, 64'(s.hz));
        write_cfg(CFG_BASE_US, s.base);
        write_cfg(CFG_RELOAD, 64'(s.reload));
        write_cfg(CFG_CPL, 64'(s.cpl));
        write_cfg(CFG_FIXED, 64'(s.fixed));
    endtask

    initial begin
        setting_t s;

        model = new;
        model.reset_state();
        idle_cycles = 0;
        stall_left  = 0;
        run_left    = 0;
        quiet_mode              <= 1'b0;
        i_rst_n                 <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_addr                <= '0;
        cfg_wdata               <= '0;
        cap_bus.valid           <= 1'b0;
        cap_bus.action          <= ACT_CAPTURE;
        cap_bus.remaining_count <= '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Out of reset the block is disabled: a capture is ignored and a
        // pop answers with an all-zero word.
        send_request(ACT_CAPTURE, 32'h1234_5678);
        send_request(ACT_POP, '0);

        // Enable only, so the other registers keep their reset values.
        settle();
        write_cfg(CFG_ENABLED, 64'd1);
        send_request(ACT_POP, '0);
        send_request(ACT_CAPTURE, 32'hFFFF_FFFF);
        send_request(ACT_CAPTURE, 32'h0000_0000);
        send_request(ACT_POP, '0);

        // Slowest clock, largest base, zero reload so the loops wrap.
        s = '{en: 1'b1, hz: 30'd1, base: '1, reload: '0, cpl: 8'd255, fixed: 8'd255};
        load_setting(s);
        send_request(ACT_CAPTURE, 32'hFFFF_FFFF);
        send_request(ACT_POP, '0);
        send_request(ACT_POP, '0);

        // Zero clock rate gives a zero quotient; zero cycles per loop adds nothing.
        s = '{en: 1'b1, hz: 30'd0, base: 64'h5555_AAAA_5555_AAAA, reload: '1,
              cpl: 8'd0, fixed: 8'd0};
        load_setting(s);
        send_request(ACT_CAPTURE, 32'h0000_0000);
        send_request(ACT_POP, '0);

        // Overfill the ring, pop while disabled, then empty it past the end.
        s = '{en: 1'b1, hz: 30'd1000000000, base: '0, reload: '1, cpl: 8'd1, fixed: 8'd0};
        load_setting(s);
        repeat (QUEUE_DEPTH_DEF) send_request(ACT_CAPTURE, $urandom);
        settle();
        write_cfg(CFG_ENABLED, 64'd0);
        send_request(ACT_POP, '0);
        settle();
        write_cfg(CFG_ENABLED, 64'd1);
        repeat (QUEUE_DEPTH_DEF) send_request(ACT_POP, '0);

        // Random phases; one is disabled, the last runs without idling.
        for (int ph = 0; ph < 9; ph++) begin
            int                 n_items;
            int                 cap_pct;
            logic [COUNT_W-1:0] rem;
            request_kind_t      kind;

            s.en = (ph != 3);
            case ($urandom_range(0, 5))
                0:       s.hz = '0;
                1:       s.hz = 30'd1000000000;
                2:       s.hz = HZ_W'($urandom_range(1, 1000));
                default: s.hz = HZ_W'($urandom_range(1, 1000000000));
            endcase
            s.base = ($urandom_range(0, 3) == 0) ? '1 : {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0:       s.reload = '0;
                1:       s.reload = '1;
                default: s.reload = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       s.cpl = 8'd255;
                1:       s.cpl = 8'd1;
                default: s.cpl = CPL_W'($urandom_range(1, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       s.fixed = 8'd0;
                1:       s.fixed = 8'd255;
                default: s.fixed = FIXED_W'($urandom_range(0, 255));
            endcase
            load_setting(s);
            quiet_mode <= (ph == 8);
            n_items = (ph == 3) ? 30 : RANDOM_ITEMS;
            cap_pct = 50;

            for (int i = 0; i < n_items; i++) begin
                // Hold off once per phase but the last until all words are out.
                if (ph != 8 && i == n_items / 2) wait_results();
                if (i % 16 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       cap_pct = 25;
                        1:       cap_pct = 50;
                        default: cap_pct = 75;
                    endcase
                end
                if (ph != 8 && $urandom_range(0, 3) == 0)
                    pause_requests($urandom_range(1, 9));
                kind = ($urandom_range(1, 100) <= cap_pct) ? ACT_CAPTURE : ACT_POP;
                case ($urandom_range(0, 7))
                    0:       rem = s.reload;
                    1:       rem = s.reload - $urandom_range(0, 1000);
                    default: rem = $urandom;
                endcase
                send_request(kind, rem);
            end
        end

        settle();
        if (model.errors == 0 && model.expected_events.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
